>>> hdl/ndrt_pkg.sv
// ----------------------------------------------------------------------------
// ndrt_pkg
// Shared types, codes and default sizes for the descriptor ring tracker.
// ----------------------------------------------------------------------------
package ndrt_pkg;

  localparam int DEF_TX_RING_SIZE  = 256;
  localparam int DEF_RX_RING_SIZE  = 256;
  localparam int DEF_TX_BATCH      = 32;
  localparam int DEF_RX_BATCH      = 128;
  localparam int DEF_MAX_FRAME     = 1500;
  localparam int DEF_RX_COPY_LIMIT = 2048;

  localparam logic [7:0] TX_CMD_BYTE = 8'h0B;  // end of packet, insert FCS

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_RECV  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  localparam logic DB_TX = 1'b0;
  localparam logic DB_RX = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] frame_length;
    logic [7:0]  device_head;
    logic        desc_done;
    logic [15:0] desc_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [11:0] length;
    logic [7:0]  desc_cmd;
    logic        head_refreshed;
    logic        clear_done;
    logic        doorbell_valid;
    logic        doorbell_queue;
    logic [7:0]  doorbell_value;
  } rsp_t;

endpackage

>>> hdl/nic_descriptor_ring_tracker.sv
// ----------------------------------------------------------------------------
// nic_descriptor_ring_tracker
// Transmit/receive descriptor ring pointer tracking with batched doorbells.
// ----------------------------------------------------------------------------
// Each request (send, flush, receive poll) produces exactly one response,
// which is registered in the cycle after it is accepted. A new request is
// taken every cycle as long as the response register is empty or is being
// drained in the same cycle; the pointer compare/increment logic between
// the request port and the response register is combinational. Doorbell
// batching uses small modulo counters that follow each tail, so no divider
// is needed for any batch size.
module nic_descriptor_ring_tracker
  import ndrt_pkg::*;
#(
  parameter int TX_RING_SIZE  = DEF_TX_RING_SIZE,
  parameter int RX_RING_SIZE  = DEF_RX_RING_SIZE,
  parameter int TX_BATCH      = DEF_TX_BATCH,
  parameter int RX_BATCH      = DEF_RX_BATCH,
  parameter int MAX_FRAME     = DEF_MAX_FRAME,
  parameter int RX_COPY_LIMIT = DEF_RX_COPY_LIMIT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int TW  = $clog2(TX_RING_SIZE);
  localparam int RW  = $clog2(RX_RING_SIZE);
  localparam int HW  = (TW > 8) ? TW : 8;
  localparam int RXW = (RW > 8) ? RW : 8;
  localparam int TBW = (TX_BATCH > 1) ? $clog2(TX_BATCH) : 1;
  localparam int RBW = (RX_BATCH > 1) ? $clog2(RX_BATCH) : 1;
  localparam int RX_TAIL_RST = RX_RING_SIZE - 1;
  localparam int RX_BCNT_RST = (RX_RING_SIZE - 1) % RX_BATCH;

  logic [TW-1:0]  tx_tail,        tx_tail_next;
  logic [HW-1:0]  tx_head_cached, tx_head_cached_next;
  logic [TW-1:0]  tx_tail_posted, tx_tail_posted_next;
  logic [TBW-1:0] tx_bcnt,        tx_bcnt_next;
  logic [RW-1:0]  rx_tail,        rx_tail_next;
  logic [RBW-1:0] rx_bcnt,        rx_bcnt_next;
  rsp_t           rsp_next;

  logic           accept;
  logic [TW-1:0]  tx_inc;
  logic [TBW-1:0] tx_binc;
  logic [RW-1:0]  rx_inc;
  logic [RBW-1:0] rx_binc;
  logic [HW-1:0]  tx_inc_ext;
  logic [HW-1:0]  tx_tail_ext;
  logic [HW-1:0]  dev_head_ext;
  logic [RXW-1:0] rx_inc_ext;
  logic           full_cached;
  logic           full_fresh;
  logic [31:0]    rx_len_clamped;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Ring and batch increments with wrap.
  always_comb begin
    tx_inc  = (tx_tail == TW'(TX_RING_SIZE - 1)) ? '0 : tx_tail + TW'(1);
    tx_binc = (tx_inc == '0 || tx_bcnt == TBW'(TX_BATCH - 1)) ? '0 : tx_bcnt + TBW'(1);
    rx_inc  = (rx_tail == RW'(RX_RING_SIZE - 1)) ? '0 : rx_tail + RW'(1);
    rx_binc = (rx_inc == '0 || rx_bcnt == RBW'(RX_BATCH - 1)) ? '0 : rx_bcnt + RBW'(1);
    tx_inc_ext   = HW'(tx_inc);
    tx_tail_ext  = HW'(tx_tail);
    dev_head_ext = HW'(req.device_head);
    rx_inc_ext   = RXW'(rx_inc);
    full_cached  = (tx_inc_ext == tx_head_cached);
    full_fresh   = (tx_inc_ext == dev_head_ext);
    rx_len_clamped = ({16'd0, req.desc_length} > 32'(RX_COPY_LIMIT)) ?
                     32'(RX_COPY_LIMIT) : {16'd0, req.desc_length};
  end

  always_comb begin
    tx_tail_next        = tx_tail;
    tx_head_cached_next = tx_head_cached;
    tx_tail_posted_next = tx_tail_posted;
    tx_bcnt_next        = tx_bcnt;
    rx_tail_next        = rx_tail;
    rx_bcnt_next        = rx_bcnt;
    rsp_next            = '0;

    case (req.kind)
      KIND_SEND: begin
        if (32'(req.frame_length) > 32'(MAX_FRAME)) begin
          rsp_next.status = ST_BAD_LEN;
        end else if (full_cached && full_fresh) begin
          tx_head_cached_next     = dev_head_ext;
          rsp_next.status         = ST_FULL;
          rsp_next.head_refreshed = 1'b1;
        end else begin
          if (full_cached) begin
            tx_head_cached_next     = dev_head_ext;
            rsp_next.head_refreshed = 1'b1;
          end
          tx_tail_next      = tx_inc;
          tx_bcnt_next      = tx_binc;
          rsp_next.status   = ST_OK;
          rsp_next.slot     = tx_tail_ext[7:0];
          rsp_next.length   = 12'(req.frame_length);
          rsp_next.desc_cmd = TX_CMD_BYTE;
          // Ring the doorbell on a batch boundary or when the tail wraps to zero.
          if (tx_binc == '0) begin
            tx_tail_posted_next     = tx_inc;
            rsp_next.doorbell_valid = 1'b1;
            rsp_next.doorbell_queue = DB_TX;
            rsp_next.doorbell_value = tx_inc_ext[7:0];
          end
        end
      end
      KIND_FLUSH: begin
        rsp_next.status = ST_OK;
        if (tx_tail != tx_tail_posted) begin
          tx_tail_posted_next     = tx_tail;
          rsp_next.doorbell_valid = 1'b1;
          rsp_next.doorbell_queue = DB_TX;
          rsp_next.doorbell_value = tx_tail_ext[7:0];
        end
      end
      KIND_RECV: begin
        if (!req.desc_done) begin
          rsp_next.status = ST_EMPTY;
        end else begin
          rx_tail_next        = rx_inc;
          rx_bcnt_next        = rx_binc;
          rsp_next.status     = ST_OK;
          rsp_next.slot       = rx_inc_ext[7:0];
          rsp_next.length     = rx_len_clamped[11:0];
          rsp_next.clear_done = 1'b1;
          if (rx_binc == '0) begin
            rsp_next.doorbell_valid = 1'b1;
            rsp_next.doorbell_queue = DB_RX;
            rsp_next.doorbell_value = rx_inc_ext[7:0];
          end
        end
      end
      default: begin
        rsp_next = '0;  // unknown operation: all-zero response, no state change
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_tail        <= '0;
      tx_head_cached <= '0;
      tx_tail_posted <= '0;
      tx_bcnt        <= '0;
      rx_tail        <= RW'(RX_TAIL_RST);
      rx_bcnt        <= RBW'(RX_BCNT_RST);
      rsp_valid      <= 1'b0;
    end else begin
      if (accept) begin
        tx_tail        <= tx_tail_next;
        tx_head_cached <= tx_head_cached_next;
        tx_tail_posted <= tx_tail_posted_next;
        tx_bcnt        <= tx_bcnt_next;
        rx_tail        <= rx_tail_next;
        rx_bcnt        <= rx_bcnt_next;
        rsp_valid      <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the descriptor ring tracker. Directed transactions
// hit length limits, flushes, empty polls and clamped receives; random
// traffic then fills and refills the transmit ring. A scoreboard predicts
// every response and compares it field by field, while the request port idles
// and the response port stalls at random.
// ----------------------------------------------------------------------------
module testbench;
  import ndrt_pkg::*;

  localparam logic [1:0]  KIND_RSVD    = 2'd3;
  localparam int          RANDOM_ITEMS = 1300;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          MAX_REPORTS  = 10;

  class ring_scoreboard;
    logic [7:0] tx_tail, tx_head_cache, tx_tail_posted, rx_tail, rx_tail_posted;
    rsp_t expected_q[$];
    int unsigned failures, reports, checked;
    int unsigned n_sent, n_rejected, n_full, n_refresh, n_tx_bell, n_rx_bell;
    int unsigned n_received, n_empty;

    function new();
      tx_tail        = '0;
      tx_head_cache  = '0;
      tx_tail_posted = '0;
      rx_tail        = 8'(DEF_RX_RING_SIZE - 1);
      rx_tail_posted = 8'(DEF_RX_RING_SIZE - 1);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function rsp_t next_ring_response(req_t r);
      rsp_t o;
      logic [7:0] nxt;
      o = '0;
      if (r.kind == KIND_SEND) begin
        if (int'(r.frame_length) > DEF_MAX_FRAME) begin
          o.status = ST_BAD_LEN;
          n_rejected++;
          return o;
        end
        nxt = 8'((int'(tx_tail) + 1) % DEF_TX_RING_SIZE);
        // ring looks full: take the device head and look again
        if (nxt == tx_head_cache) begin
          tx_head_cache    = r.device_head;
          o.head_refreshed = 1'b1;
          n_refresh++;
        end
        if (nxt == tx_head_cache) begin
          o.status = ST_FULL;
          n_full++;
          return o;
        end
        o.status   = ST_OK;
        o.slot     = tx_tail;
        o.length   = 12'(r.frame_length);
        o.desc_cmd = TX_CMD_BYTE;
        tx_tail    = nxt;
        n_sent++;
        if (int'(tx_tail) % DEF_TX_BATCH == 0) begin
          tx_tail_posted   = tx_tail;
          o.doorbell_valid = 1'b1;
          o.doorbell_queue = DB_TX;
          o.doorbell_value = tx_tail;
          n_tx_bell++;
        end
      end else if (r.kind == KIND_FLUSH) begin
        if (tx_tail != tx_tail_posted) begin
          tx_tail_posted   = tx_tail;
          o.doorbell_valid = 1'b1;
          o.doorbell_queue = DB_TX;
          o.doorbell_value = tx_tail;
          n_tx_bell++;
        end
      end else if (r.kind == KIND_RECV) begin
        if (!r.desc_done) begin
          o.status = ST_EMPTY;
          n_empty++;
          return o;
        end
        nxt          = 8'((int'(rx_tail) + 1) % DEF_RX_RING_SIZE);
        rx_tail      = nxt;
        o.slot       = nxt;
        o.clear_done = 1'b1;
        o.length     = (int'(r.desc_length) > DEF_RX_COPY_LIMIT) ?
                       12'(DEF_RX_COPY_LIMIT) : 12'(r.desc_length);
        n_received++;
        if (int'(rx_tail) % DEF_RX_BATCH == 0) begin
          rx_tail_posted   = rx_tail;
          o.doorbell_valid = 1'b1;
          o.doorbell_queue = DB_RX;
          o.doorbell_value = rx_tail;
          n_rx_bell++;
        end
      end
      return o;
    endfunction

    function void note_request(req_t r);
      expected_q.push_back(next_ring_response(r));
    endfunction

    function string fmt(rsp_t x);
      return $sformatf("st=%0d slot=%0d len=%0d cmd=%h ref=%b clr=%b db=%b q=%b val=%0d",
                       x.status, x.slot, x.length, x.desc_cmd, x.head_refreshed,
                       x.clear_done, x.doorbell_valid, x.doorbell_queue,
                       x.doorbell_value);
    endfunction

    function void check_response(rsp_t a);
      rsp_t e;
      bit bad;
      if (expected_q.size() == 0) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected response: %s", $time, fmt(a));
        end
        return;
      end
      e = expected_q.pop_front();
      checked++;
      bad = (a.status !== e.status) || (a.slot !== e.slot) ||
            (a.length !== e.length) || (a.desc_cmd !== e.desc_cmd) ||
            (a.head_refreshed !== e.head_refreshed) ||
            (a.clear_done !== e.clear_done) ||
            (a.doorbell_valid !== e.doorbell_valid) ||
            (a.doorbell_queue !== e.doorbell_queue) ||
            (a.doorbell_value !== e.doorbell_value);
      if (bad) begin
        failures++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: mismatch on response %0d", $time, checked);
          $display("  expected: %s", fmt(e));
          $display("  actual:   %s", fmt(a));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  ring_scoreboard sb;
  int unsigned    cycle_count;
  bit             random_phase;
  bit             hold_done;
  int             burst_left;

  nic_descriptor_ring_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    rsp_stall    = 1'b0;
    cycle_count  = 0;
    random_phase = 1'b0;
    hold_done    = 1'b0;
    burst_left   = 0;
    sb           = new();
  end

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("run aborted after %0d cycles, %0d responses outstanding",
             cycle_count, sb.pending());
    $display("TEST FAILED");
    $finish;
  end

  // Record accepted transactions on both ports.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.note_request(req);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end
  end

  // Response side stall pattern, with one long hold early in the random traffic.
  initial begin
    int unsigned mode;
    int unsigned seg;
    forever begin
      if (random_phase && !hold_done) begin
        @(negedge clk);
        rsp_stall <= 1'b1;
        repeat (250) @(negedge clk);
        rsp_stall <= 1'b0;
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        seg  = $urandom_range(20, 200);
        repeat (seg) begin
          @(negedge clk);
          case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
          endcase
        end
      end
    end
  end

  function automatic req_t make_req(logic [1:0] kind, int flen, int dhead,
                                    bit done, int dlen);
    req_t r;
    r.kind         = kind;
    r.frame_length = 11'(flen);
    r.device_head  = 8'(dhead);
    r.desc_done    = done;
    r.desc_length  = 16'(dlen);
    return r;
  endfunction

  function automatic logic [7:0] tx_next();
    return 8'((int'(sb.tx_tail) + 1) % DEF_TX_RING_SIZE);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int unsigned pick;
    logic [7:0] nxt;
    r.frame_length = 11'($urandom_range(0, 2047));
    r.device_head  = 8'($urandom);
    r.desc_done    = 1'($urandom);
    r.desc_length  = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 58)      r.kind = KIND_SEND;
    else if (pick < 70) r.kind = KIND_FLUSH;
    else if (pick < 97) r.kind = KIND_RECV;
    else                r.kind = KIND_RSVD;

    if (r.kind == KIND_SEND) begin
      pick = $urandom_range(0, 9);
      if (pick < 8)       r.frame_length = 11'($urandom_range(0, DEF_MAX_FRAME));
      else if (pick == 8) r.frame_length = 11'($urandom_range(DEF_MAX_FRAME + 1, 2047));
      else begin
        case ($urandom_range(0, 3))
          0: r.frame_length = 11'd0;
          1: r.frame_length = 11'(DEF_MAX_FRAME);
          2: r.frame_length = 11'(DEF_MAX_FRAME + 1);
          default: r.frame_length = 11'd2047;
        endcase
      end
      // keep the device head close to the tail so the ring fills often
      nxt  = tx_next();
      pick = $urandom_range(0, 9);
      if (pick < 3)      r.device_head = nxt;
      else if (pick < 8) r.device_head = nxt + 8'($urandom_range(1, 12));
    end else if (r.kind == KIND_RECV) begin
      r.desc_done = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 4))
        0, 1: r.desc_length = 16'($urandom_range(0, DEF_RX_COPY_LIMIT));
        2: r.desc_length = 16'($urandom_range(DEF_RX_COPY_LIMIT + 1, 65535));
        3: r.desc_length = 16'($urandom);
        default: begin
          case ($urandom_range(0, 4))
            0: r.desc_length = 16'd0;
            1: r.desc_length = 16'(DEF_RX_COPY_LIMIT - 1);
            2: r.desc_length = 16'(DEF_RX_COPY_LIMIT);
            3: r.desc_length = 16'(DEF_RX_COPY_LIMIT + 1);
            default: r.desc_length = 16'hFFFF;
          endcase
        end
      endcase
    end
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    req_t directed[$];
    int   counted;
    bit   paused;
    req_t r;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed.push_back(make_req(KIND_SEND, 0, 0, 0, 0));
    directed.push_back(make_req(KIND_SEND, DEF_MAX_FRAME, 255, 1, 65535));
    directed.push_back(make_req(KIND_SEND, DEF_MAX_FRAME + 1, 0, 0, 0));
    directed.push_back(make_req(KIND_SEND, 2047, 255, 1, 65535));
    directed.push_back(make_req(KIND_SEND, 64, 255, 0, 0));
    directed.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0));
    directed.push_back(make_req(KIND_FLUSH, 2047, 255, 1, 65535));
    directed.push_back(make_req(KIND_RECV, 0, 0, 0, 100));
    directed.push_back(make_req(KIND_RECV, 0, 0, 1, 0));
    directed.push_back(make_req(KIND_RECV, 0, 0, 1, DEF_RX_COPY_LIMIT - 1));
    directed.push_back(make_req(KIND_RECV, 0, 0, 1, DEF_RX_COPY_LIMIT));
    directed.push_back(make_req(KIND_RECV, 0, 0, 1, DEF_RX_COPY_LIMIT + 1));
    directed.push_back(make_req(KIND_RECV, 2047, 255, 1, 65535));
    directed.push_back(make_req(KIND_RSVD, 2047, 255, 1, 65535));
    directed.push_back(make_req(KIND_RECV, 2047, 255, 0, 65535));
    directed.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0));
    directed.push_back(make_req(KIND_SEND, 1, 0, 1, 1));
    directed.push_back(make_req(KIND_FLUSH, 0, 0, 0, 0));

    foreach (directed[i]) begin
      pace();
      offer(directed[i]);
    end
    drain();

    random_phase = 1'b1;
    counted = 0;
    paused  = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      pace();
      r = random_request();
      offer(r);
      // reserved kinds change no state in the block, so skip them in the tally
      if (r.kind != KIND_RSVD) counted++;
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    req_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d responses: %0d sends, %0d rejected, %0d ring full, %0d head refreshes",
             sb.checked, sb.n_sent, sb.n_rejected, sb.n_full, sb.n_refresh);
    $display("received %0d, empty polls %0d, tx doorbells %0d, rx doorbells %0d, failures %0d",
             sb.n_received, sb.n_empty, sb.n_tx_bell, sb.n_rx_bell, sb.failures);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
hdl/ndrt_pkg.sv
hdl/nic_descriptor_ring_tracker.sv
test/testbench.sv
